// ===== rtl/selsort_pkg.sv =====
// shared types and constants for the selection-sort controller
package selsort_pkg;

    typedef enum logic [3:0] {
        ST_INIT      = 4'd0,
        ST_WAIT_LOW  = 4'd1,
        ST_SETUP     = 4'd2,
        ST_OUTER     = 4'd3,
        ST_LOAD_MIN  = 4'd4,
        ST_READ_DATA = 4'd5,
        ST_COMPARE   = 4'd6,
        ST_NEW_MIN   = 4'd7,
        ST_SCAN_NEXT = 4'd8,
        ST_INNER_INC = 4'd9,
        ST_SWAP_READ = 4'd10,
        ST_SWAP_WR1  = 4'd11,
        ST_SWAP_WR2  = 4'd12,
        ST_DONE      = 4'd13
    } state_t;

    localparam logic [1:0] ADDR_OUTER = 2'd0;
    localparam logic [1:0] ADDR_INNER = 2'd1;
    localparam logic [1:0] ADDR_MIN   = 2'd2;

    localparam logic DATA_MIN = 1'b0;
    localparam logic DATA_REG = 1'b1;

    localparam logic MIN_FROM_OUTER = 1'b0;
    localparam logic MIN_FROM_INNER = 1'b1;

    typedef struct packed {
        logic [1:0] outer_ctrl;
        logic [2:0] inner_ctrl;
        logic       load_min_address;
        logic       load_min_value;
        logic       load_data_value;
        logic [1:0] address_select;
        logic       data_select;
        logic       min_select;
        logic       mem_read;
        logic       mem_write;
        logic       sort_done;
    } ctrl_word_t;

endpackage

// ===== rtl/selsort_decode.sv =====
// control word decode of the present state
module selsort_decode
(
    input  logic [3:0]               state,
    output selsort_pkg::ctrl_word_t  ctrl
);

    always_comb
    begin
        ctrl = '0;
        case (state)
            selsort_pkg::ST_SETUP:
            begin
                ctrl.outer_ctrl = 2'b11;
                ctrl.inner_ctrl = 3'b011;
            end
            selsort_pkg::ST_OUTER:
            begin
                ctrl.inner_ctrl = 3'b101;
            end
            selsort_pkg::ST_LOAD_MIN:
            begin
                ctrl.address_select   = selsort_pkg::ADDR_OUTER;
                ctrl.mem_read         = 1'b1;
                ctrl.load_min_value   = 1'b1;
                ctrl.load_min_address = 1'b1;
                ctrl.min_select       = selsort_pkg::MIN_FROM_OUTER;
            end
            selsort_pkg::ST_READ_DATA:
            begin
                ctrl.address_select  = selsort_pkg::ADDR_INNER;
                ctrl.mem_read        = 1'b1;
                ctrl.load_data_value = 1'b1;
            end
            selsort_pkg::ST_NEW_MIN:
            begin
                ctrl.address_select   = selsort_pkg::ADDR_INNER;
                ctrl.mem_read         = 1'b1;
                ctrl.load_min_value   = 1'b1;
                ctrl.load_min_address = 1'b1;
                ctrl.min_select       = selsort_pkg::MIN_FROM_INNER;
            end
            selsort_pkg::ST_INNER_INC:
            begin
                ctrl.inner_ctrl = 3'b001;
            end
            selsort_pkg::ST_SWAP_READ:
            begin
                ctrl.address_select  = selsort_pkg::ADDR_OUTER;
                ctrl.mem_read        = 1'b1;
                ctrl.load_data_value = 1'b1;
            end
            selsort_pkg::ST_SWAP_WR1:
            begin
                ctrl.mem_write      = 1'b1;
                ctrl.data_select    = selsort_pkg::DATA_MIN;
                ctrl.address_select = selsort_pkg::ADDR_OUTER;
            end
            selsort_pkg::ST_SWAP_WR2:
            begin
                ctrl.mem_write      = 1'b1;
                ctrl.data_select    = selsort_pkg::DATA_REG;
                ctrl.address_select = selsort_pkg::ADDR_MIN;
                ctrl.outer_ctrl     = 2'b01;
            end
            selsort_pkg::ST_DONE:
            begin
                ctrl.sort_done = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// ===== rtl/selection_sort_control_fsm_top.sv =====
// top level of the selection-sort control state machine
// Usage:
//   input channel (in_valid/in_ready) carries one evaluation per item: start_req,
//   outer_carry, inner_carry, less_than, restart and clock_edge.
//   output channel (out_valid/out_ready) returns one control word per item,
//   the word of the state held when the item was accepted.
//   latency: the result is valid the cycle after the item is accepted.
//   throughput: one item per cycle while out_ready keeps the result draining; the state
//   register and the result register are the only stages, with one level of decode between them.
//   in_ready is high while the result register is empty or being drained,
//   so a stalled receiver holds the result and stops new items after one.
//   the state moves only when an item is accepted: restart clears it to
//   the initialise state, otherwise clock_edge advances it.
//   reset (rst_n low) clears the state to the initialise state and
//   empties the result register.
//   unused state codes give an all-zero control word and return to the
//   initialise state when the next accepted item restarts or advances it.
module selection_sort_control_fsm_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       start_req,
    input  logic       outer_carry,
    input  logic       inner_carry,
    input  logic       less_than,
    input  logic       restart,
    input  logic       clock_edge,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] outer_ctrl,
    output logic [2:0] inner_ctrl,
    output logic       load_min_address,
    output logic       load_min_value,
    output logic       load_data_value,
    output logic [1:0] address_select,
    output logic       data_select,
    output logic       min_select,
    output logic       mem_read,
    output logic       mem_write,
    output logic       sort_done
);

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic [3:0]              fsm_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    selsort_pkg::ctrl_word_t ctrl;
    selsort_pkg::ctrl_word_t ctrl_reg;
    logic                    accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    selsort_decode u_decode
    (
        .state (state_reg),
        .ctrl  (ctrl)
    );

    // next state
    always_comb
    begin
        case (state_reg)
            selsort_pkg::ST_INIT:
                fsm_next = start_req ? selsort_pkg::ST_WAIT_LOW : selsort_pkg::ST_INIT;
            selsort_pkg::ST_WAIT_LOW:
                fsm_next = start_req ? selsort_pkg::ST_WAIT_LOW : selsort_pkg::ST_SETUP;
            selsort_pkg::ST_SETUP:
                fsm_next = selsort_pkg::ST_OUTER;
            selsort_pkg::ST_OUTER:
                fsm_next = outer_carry ? selsort_pkg::ST_DONE : selsort_pkg::ST_LOAD_MIN;
            selsort_pkg::ST_LOAD_MIN:
                fsm_next = selsort_pkg::ST_READ_DATA;
            selsort_pkg::ST_READ_DATA:
                fsm_next = selsort_pkg::ST_COMPARE;
            selsort_pkg::ST_COMPARE:
                fsm_next = less_than ? selsort_pkg::ST_NEW_MIN : selsort_pkg::ST_SCAN_NEXT;
            selsort_pkg::ST_NEW_MIN:
                fsm_next = selsort_pkg::ST_SCAN_NEXT;
            selsort_pkg::ST_SCAN_NEXT:
                fsm_next = selsort_pkg::ST_INNER_INC;
            selsort_pkg::ST_INNER_INC:
                fsm_next = inner_carry ? selsort_pkg::ST_SWAP_READ
                                       : selsort_pkg::ST_READ_DATA;
            selsort_pkg::ST_SWAP_READ:
                fsm_next = selsort_pkg::ST_SWAP_WR1;
            selsort_pkg::ST_SWAP_WR1:
                fsm_next = selsort_pkg::ST_SWAP_WR2;
            selsort_pkg::ST_SWAP_WR2:
                fsm_next = selsort_pkg::ST_OUTER;
            default:
                fsm_next = selsort_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            if (restart)
            begin
                state_next = selsort_pkg::ST_INIT;
            end
            else if (clock_edge)
            begin
                state_next = fsm_next;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= selsort_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg <= ctrl;
        end
    end

    assign out_valid        = out_valid_reg;
    assign outer_ctrl       = ctrl_reg.outer_ctrl;
    assign inner_ctrl       = ctrl_reg.inner_ctrl;
    assign load_min_address = ctrl_reg.load_min_address;
    assign load_min_value   = ctrl_reg.load_min_value;
    assign load_data_value  = ctrl_reg.load_data_value;
    assign address_select   = ctrl_reg.address_select;
    assign data_select      = ctrl_reg.data_select;
    assign min_select       = ctrl_reg.min_select;
    assign mem_read         = ctrl_reg.mem_read;
    assign mem_write        = ctrl_reg.mem_write;
    assign sort_done        = ctrl_reg.sort_done;

endmodule
